FILE: hdl/double_error_syndrome_corrector_macros.svh
// Assertion macros used by the checker of this block.
`ifndef DOUBLE_ERROR_SYNDROME_CORRECTOR_MACROS_SVH
`define DOUBLE_ERROR_SYNDROME_CORRECTOR_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define DESC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("desc check failed");

// Next-cycle implication, off while reset is high.
`define DESC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("desc check failed");

`endif

FILE: hdl/desc_pkg.sv
package desc_pkg;

   localparam int ROW_COUNT      = 8;
   localparam int WORD_BITS      = 16;
   localparam int SYN_BITS       = ROW_COUNT;
   localparam int POS_BITS       = 4;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int REG_INDEX_LSB  = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int RSP_DATA_BITS  = 48;

   typedef logic [WORD_BITS-1:0]                 word_type;
   typedef logic [SYN_BITS-1:0]                  syn_type;
   typedef logic [POS_BITS-1:0]                  pos_type;
   typedef logic [ROW_COUNT-1:0][WORD_BITS-1:0]  rows_type;
   typedef logic [WORD_BITS-1:0][SYN_BITS-1:0]   cols_type;
   typedef logic [WORD_BITS-1:0][WORD_BITS-1:0]  pair_type;

   localparam word_type MSB_MASK = word_type'(1) << (WORD_BITS - 1);

   typedef enum logic [1:0] {
      STATUS_CLEAN  = 2'd0,
      STATUS_SINGLE = 2'd1,
      STATUS_DOUBLE = 2'd2,
      STATUS_UNCORR = 2'd3
   } status_type;

   // stage 1 -> 2
   typedef struct packed {
      word_type word;
      syn_type  syn;
   } syn_stage_type;

   // stage 2 -> 3
   typedef struct packed {
      word_type word;
      syn_type  syn;
      word_type single_hit;   // bit i: column i equals syndrome
      pair_type pair_hit;     // [i][j]: column i ^ column j equals syndrome, i != j
   } match_stage_type;

   // stage 3 -> 4
   typedef struct packed {
      word_type   word;
      syn_type    syn;
      status_type status;
      pos_type    first;
      word_type   pair_row;   // pair hits of the chosen first column
   } locate_stage_type;

   // stage 4 -> output
   typedef struct packed {
      word_type   word;
      syn_type    syn;
      status_type status;
      pos_type    first;
      pos_type    second;
   } result_type;

   // column c: bit (15-c) of each row, row 0 in the top bit
   function automatic cols_type columns_of(rows_type rows);
      cols_type cols;
      for (int c = 0; c < WORD_BITS; c++) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            cols[c][SYN_BITS-1-r] = rows[r][WORD_BITS-1-c];
         end
      end
      return cols;
   endfunction

endpackage

FILE: hdl/desc_syndrome.sv
module desc_syndrome (
   input  logic                        clock,
   input  logic                        load,
   input  desc_pkg::word_type          word,
   input  desc_pkg::rows_type          rows,
   output desc_pkg::syn_stage_type     stage_out
);

   desc_pkg::syn_stage_type stage_ff, stage_in;

   always_comb begin
      stage_in.word = word;
      for (int r = 0; r < desc_pkg::ROW_COUNT; r++) begin
         stage_in.syn[desc_pkg::SYN_BITS-1-r] = ^(word & rows[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

FILE: hdl/desc_match.sv
module desc_match (
   input  logic                        clock,
   input  logic                        load,
   input  desc_pkg::syn_stage_type     stage_in_data,
   input  desc_pkg::rows_type          rows,
   output desc_pkg::match_stage_type   stage_out
);

   desc_pkg::match_stage_type stage_ff, stage_in;
   desc_pkg::cols_type        cols;

   assign cols = desc_pkg::columns_of(rows);

   // all single and pair compares in parallel
   always_comb begin
      stage_in.word = stage_in_data.word;
      stage_in.syn  = stage_in_data.syn;
      for (int i = 0; i < desc_pkg::WORD_BITS; i++) begin
         stage_in.single_hit[i] = (cols[i] == stage_in_data.syn);
         for (int j = 0; j < desc_pkg::WORD_BITS; j++) begin
            stage_in.pair_hit[i][j] = (i != j) && ((cols[i] ^ cols[j]) == stage_in_data.syn);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

FILE: hdl/desc_locate.sv
module desc_locate (
   input  logic                        clock,
   input  logic                        load,
   input  desc_pkg::match_stage_type   stage_in_data,
   output desc_pkg::locate_stage_type  stage_out
);

   desc_pkg::locate_stage_type stage_ff, stage_in;
   logic                       found;
   desc_pkg::pos_type          idx;

   // lowest column with a single or pair hit wins
   always_comb begin
      found = 1'b0;
      idx   = '0;
      for (int i = desc_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (stage_in_data.single_hit[i] || (|stage_in_data.pair_hit[i])) begin
            found = 1'b1;
            idx   = desc_pkg::pos_type'(i);
         end
      end
   end

   always_comb begin
      stage_in.word     = stage_in_data.word;
      stage_in.syn      = stage_in_data.syn;
      stage_in.first    = '0;
      stage_in.pair_row = '0;
      priority if (stage_in_data.syn == '0) begin
         stage_in.status = desc_pkg::STATUS_CLEAN;
      end else if (!found) begin
         stage_in.status = desc_pkg::STATUS_UNCORR;
      end else if (stage_in_data.single_hit[idx]) begin
         stage_in.status = desc_pkg::STATUS_SINGLE;
         stage_in.first  = idx;
      end else begin
         stage_in.status   = desc_pkg::STATUS_DOUBLE;
         stage_in.first    = idx;
         stage_in.pair_row = stage_in_data.pair_hit[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

FILE: hdl/desc_correct.sv
module desc_correct (
   input  logic                        clock,
   input  logic                        load,
   input  desc_pkg::locate_stage_type  stage_in_data,
   output desc_pkg::result_type        result
);

   desc_pkg::result_type result_ff, result_in;
   desc_pkg::pos_type    second;
   desc_pkg::word_type   flip;

   // lowest partner column
   always_comb begin
      second = '0;
      for (int j = desc_pkg::WORD_BITS - 1; j >= 0; j--) begin
         if (stage_in_data.pair_row[j]) begin
            second = desc_pkg::pos_type'(j);
         end
      end
   end

   always_comb begin
      result_in.syn    = stage_in_data.syn;
      result_in.status = stage_in_data.status;
      result_in.first  = stage_in_data.first;
      result_in.second = '0;
      unique case (stage_in_data.status)
         desc_pkg::STATUS_SINGLE: begin
            flip = desc_pkg::MSB_MASK >> stage_in_data.first;
         end
         desc_pkg::STATUS_DOUBLE: begin
            flip = (desc_pkg::MSB_MASK >> stage_in_data.first)
                 ^ (desc_pkg::MSB_MASK >> second);
            result_in.second = second;
         end
         default: begin
            flip = '0;
         end
      endcase
      result_in.word = stage_in_data.word ^ flip;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: hdl/double_error_syndrome_corrector.sv
// Channel  | Dir | Payload
// ---------+-----+-----------------------------------------------------------
// req_     | in  | tdata[15:0] received_word
// rsp_     | out | tdata: corrected_word, data_byte, syndrome, error_status,
//          |     |        first_position, second_position (lowest bit up)
// csr_     | cfg | APB, parity_row_0..7 at byte address 4*i
//
// One codeword per cycle while rsp_ keeps up; rsp valid follows the req transfer
// through four register stages: syndrome, column compares, first column pick,
// partner pick and bit flip.
// Reset clears the valid bits and the parity rows; no memory to sweep.
// Each stage holds while full and blocked downstream; bubbles close up, so
// req_tready stays high while any stage is empty even when rsp_ stalls.
module double_error_syndrome_corrector (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [desc_pkg::WORD_BITS-1:0]    req_tdata,   // [15:0] received_word

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] corrected_word, [23:16] data_byte, [31:24] syndrome,
   // [33:32] error_status, [37:34] first_position, [41:38] second_position, rest 0
   output logic [desc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [desc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [desc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [desc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int IDX_BITS = desc_pkg::CSR_ADDR_BITS - desc_pkg::REG_INDEX_LSB;

   // ---------------- configuration ----------------
   desc_pkg::rows_type        rows_ff;
   logic [IDX_BITS-1:0]       csr_index;
   logic                      csr_write;

   assign csr_index  = csr_paddr[desc_pkg::CSR_ADDR_BITS-1:desc_pkg::REG_INDEX_LSB];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = desc_pkg::CSR_DATA_BITS'(rows_ff[csr_index]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else if (csr_write) begin
         rows_ff[csr_index] <= csr_pwdata[desc_pkg::WORD_BITS-1:0];
      end
   end

   // ---------------- pipeline control ----------------
   // A stage loads when it is empty or its successor loads this cycle.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign v1_in = en1 ? req_tvalid : v1_ff;
   assign v2_in = en2 ? v1_ff      : v2_ff;
   assign v3_in = en3 ? v2_ff      : v3_ff;
   assign v4_in = en4 ? v3_ff      : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_tready = en1;
   assign rsp_tvalid = v4_ff;

   // ---------------- datapath stages ----------------
   desc_pkg::syn_stage_type    s1;
   desc_pkg::match_stage_type  s2;
   desc_pkg::locate_stage_type s3;
   desc_pkg::result_type       s4;

   // stage 1: syndrome, one parity tree per row
   desc_syndrome u_syndrome (
      .clock     (clock),
      .load      (en1),
      .word      (req_tdata),
      .rows      (rows_ff),
      .stage_out (s1)
   );

   // stage 2: every column and column pair against the syndrome
   desc_match u_match (
      .clock         (clock),
      .load          (en2),
      .stage_in_data (s1),
      .rows          (rows_ff),
      .stage_out     (s2)
   );

   // stage 3: first column in search order, status
   desc_locate u_locate (
      .clock         (clock),
      .load          (en3),
      .stage_in_data (s2),
      .stage_out     (s3)
   );

   // stage 4: partner column, flip, output register
   desc_correct u_correct (
      .clock         (clock),
      .load          (en4),
      .stage_in_data (s3),
      .result        (s4)
   );

   assign rsp_tdata = {6'b0, s4.second, s4.first, s4.status, s4.syn,
                       s4.word[desc_pkg::WORD_BITS-1:8], s4.word};

endmodule

FILE: hdl/desc_checker.sv
`include "double_error_syndrome_corrector_macros.svh"

module desc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // held result stays put
   `DESC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // data byte mirrors the upper corrected byte
   `DESC_ASSERT_NOW(a_data_byte, clock, reset, rsp_tvalid, rsp_tdata[23:16] == rsp_tdata[15:8])

   // clean exactly when the syndrome is zero, with both positions zero
   `DESC_ASSERT_NOW(a_clean, clock, reset, rsp_tvalid, (rsp_tdata[31:24] == 8'd0) == (rsp_tdata[33:32] == 2'd0) && (rsp_tdata[33:32] != 2'd0 || rsp_tdata[41:34] == 8'd0))

   // second position only on a double correction
   `DESC_ASSERT_NOW(a_second, clock, reset, rsp_tvalid && rsp_tdata[33:32] != 2'd2, rsp_tdata[41:38] == 4'd0)

   // an empty output means the pipe has room
   `DESC_ASSERT_NOW(a_room, clock, reset, !rsp_tvalid, req_tready)

endmodule

bind double_error_syndrome_corrector desc_checker u_desc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: verif/double_error_syndrome_corrector_tb.sv
module double_error_syndrome_corrector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import desc_pkg::*;

   // How the parity-check matrix is filled for one stretch of traffic.
   typedef enum {
      MATRIX_ZERO,
      MATRIX_ONES,
      MATRIX_RANDOM,
      MATRIX_SPARSE,
      MATRIX_REPEATED
   } matrix_kind_type;

   // Which side of the stream inserts bubbles.
   typedef enum {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                      clock;
   logic                      reset;

   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [WORD_BITS-1:0]      req_tdata   = '0;     // [15:0] received_word

   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   // [15:0] corrected_word, [23:16] data_byte, [31:24] syndrome,
   // [33:32] error_status, [37:34] first_position, [41:38] second_position
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   // Local copy of the parity rows, updated as each row is written.
   word_type   parity_matrix [ROW_COUNT];
   // Decodes predicted for accepted words, oldest first.
   result_type pending_results [$];
   // Every word with a zero syndrome under the current matrix.
   word_type   codewords [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count     = 0;

   double_error_syndrome_corrector i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("double_error_syndrome_corrector regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor: syndrome, then the ordered column / column-pair search.
   // ------------------------------------------------------------------
   function automatic result_type predict_result(word_type word);
      result_type res;
      syn_type    col [WORD_BITS];
      logic       found;
      res.word   = word;
      res.syn    = '0;
      res.status = STATUS_CLEAN;
      res.first  = '0;
      res.second = '0;
      found      = 1'b0;
      // row r feeds syndrome bit 7-r
      for (int r = 0; r < ROW_COUNT; r++)
         res.syn[SYN_BITS-1-r] = ^(word & parity_matrix[r]);
      // column c is word bit 15-c of each row, row 0 on top
      for (int c = 0; c < WORD_BITS; c++)
         for (int r = 0; r < ROW_COUNT; r++)
            col[c][SYN_BITS-1-r] = parity_matrix[r][WORD_BITS-1-c];
      if (res.syn != '0) begin
         res.status = STATUS_UNCORR;
         // column i alone beats every pair that starts at i
         for (int i = 0; i < WORD_BITS; i++) begin
            if (!found && col[i] == res.syn) begin
               res.status = STATUS_SINGLE;
               res.first  = pos_type'(i);
               found      = 1'b1;
            end
            for (int j = 0; j < WORD_BITS; j++) begin
               if (!found && j != i && (col[i] ^ col[j]) == res.syn) begin
                  res.status = STATUS_DOUBLE;
                  res.first  = pos_type'(i);
                  res.second = pos_type'(j);
                  found      = 1'b1;
               end
            end
         end
         if (res.status == STATUS_SINGLE) begin
            res.word = word ^ (MSB_MASK >> res.first);
         end else if (res.status == STATUS_DOUBLE) begin
            res.word = word ^ (MSB_MASK >> res.first) ^ (MSB_MASK >> res.second);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got,
                                  logic [63:0] want);
      mismatch_count++;
      $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   task automatic compare_field(string what, logic [63:0] got,
                                logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Zero-syndrome words are the base of the well-formed stimulus.
   function automatic void collect_codewords();
      logic zero;
      codewords.delete();
      for (int w = 0; w < (1 << WORD_BITS); w++) begin
         zero = 1'b1;
         for (int r = 0; r < ROW_COUNT; r++)
            if (^(word_type'(w) & parity_matrix[r]))
               zero = 1'b0;
         if (zero)
            codewords.push_back(word_type'(w));
      end
   endfunction

   // Mostly codewords with one or two flipped bits, some raw noise.
   function automatic word_type random_word();
      word_type base;
      base = codewords[$urandom_range(0, codewords.size() - 1)];
      case ($urandom_range(0, 9))
         0, 1, 2: return word_type'($urandom());
         3, 4, 5: return base ^ (MSB_MASK >> $urandom_range(0, WORD_BITS - 1));
         6, 7, 8: return base ^ (MSB_MASK >> $urandom_range(0, WORD_BITS - 1))
                              ^ (MSB_MASK >> $urandom_range(0, WORD_BITS - 1));
         default: return base;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result side: random backpressure, checked at the rising edge.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(1, 100) > receiver_stall_pct);
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing pending", rsp_tdata, 0);
         end else begin
            want = pending_results.pop_front();
            compare_field("corrected_word",  rsp_tdata[15:0],  want.word);
            compare_field("data_byte",       rsp_tdata[23:16], want.word[15:8]);
            compare_field("syndrome",        rsp_tdata[31:24], want.syn);
            compare_field("error_status",    rsp_tdata[33:32], want.status);
            compare_field("first_position",  rsp_tdata[37:34], want.first);
            compare_field("second_position", rsp_tdata[41:38], want.second);
            compare_field("tdata padding",   rsp_tdata[47:42], 0);
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------
   // One word; the prediction is queued at the accepting edge.
   task automatic send_word(word_type word);
      @(negedge clock);
      while ($urandom_range(1, 100) <= sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_result(word));
   endtask

   // Drop valid, let every result out, then cover the 4-stage latency.
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // APB setup + access; the transfer completes on psel & penable & pready.
   task automatic csr_access(input logic write_op, input int index,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_op;
      csr_paddr   <= CSR_ADDR_BITS'(index << REG_INDEX_LSB);
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Upper data bits are junk on purpose: the row keeps only 16 bits.
   task automatic write_parity_row(int index, word_type row);
      logic [CSR_DATA_BITS-1:0] readback;
      csr_access(1'b1, index, {16'($urandom()), row}, readback);
      parity_matrix[index] = row;
      csr_access(1'b0, index, '0, readback);
      compare_field($sformatf("parity_row_%0d readback", index), readback, row);
   endtask

   task automatic load_matrix(matrix_kind_type kind);
      word_type rows [ROW_COUNT];
      cols_type cols;
      syn_type  palette [4];
      case (kind)
         MATRIX_ZERO: rows = '{default: '0};
         MATRIX_ONES: rows = '{default: '1};
         MATRIX_RANDOM: begin
            foreach (rows[r]) rows[r] = word_type'($urandom());
         end
         MATRIX_SPARSE: begin
            // many zero and repeated columns
            foreach (rows[r]) rows[r] = word_type'($urandom() & $urandom() & $urandom());
         end
         MATRIX_REPEATED: begin
            // four distinct columns at most, one of them often zero
            foreach (palette[k])
               palette[k] = ($urandom_range(0, 3) == 0) ? '0 : syn_type'($urandom());
            for (int c = 0; c < WORD_BITS; c++)
               cols[c] = palette[$urandom_range(0, 3)];
            for (int r = 0; r < ROW_COUNT; r++)
               for (int c = 0; c < WORD_BITS; c++)
                  rows[r][WORD_BITS-1-c] = cols[c][SYN_BITS-1-r];
         end
         default: rows = '{default: '0};
      endcase
      for (int r = 0; r < ROW_COUNT; r++)
         write_parity_row(r, rows[r]);
      collect_codewords();
   endtask

   task automatic set_idle_mode(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
         IDLE_BOTH:     begin sender_idle_pct = 22; receiver_stall_pct = 22; end
         default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Rows read back as zero; with an all-zero matrix every word is clean.
   task automatic test_reset_state();
      logic [CSR_DATA_BITS-1:0] readback;
      set_idle_mode(IDLE_NONE);
      for (int r = 0; r < ROW_COUNT; r++) begin
         csr_access(1'b0, r, '0, readback);
         compare_field($sformatf("parity_row_%0d after reset", r), readback, 0);
         parity_matrix[r] = '0;
      end
      send_word(16'h0000);
      send_word(16'hFFFF);
      send_word(16'hA5A5);
      send_word(16'h5A5A);
      drain_pipeline();
   endtask

   task automatic test_directed_cases();
      set_idle_mode(IDLE_BOTH);
      // columns 0..7 are unit vectors, 8..14 zero, 15 all ones
      for (int r = 0; r < ROW_COUNT; r++)
         write_parity_row(r, (MSB_MASK >> r) | word_type'(1));
      send_word(16'h0000);   // clean
      send_word(16'h8000);   // single, column 0
      send_word(16'h0100);   // single, column 7
      send_word(16'hC000);   // pair that starts at column 0
      send_word(16'h8100);   // pair (0,7)
      send_word(16'hE000);   // three units: no match
      send_word(16'h0001);   // zero column pairs with column 15 before 15 alone
      send_word(16'h0080);   // zero column: error is invisible, word kept
      send_word(16'hFFFF);
      send_word(16'hAAAA);
      send_word(16'h5555);
      drain_pipeline();
      // all-ones matrix: syndrome is 0 or FF, and FF is column 0 alone
      for (int r = 0; r < ROW_COUNT; r++)
         write_parity_row(r, '1);
      send_word(16'h0001);
      send_word(16'h8000);
      send_word(16'hFFFF);
      send_word(16'h7FFF);
      drain_pipeline();
   endtask

   task automatic test_random_phase(matrix_kind_type kind, idle_mode_type mode,
                                    int count);
      load_matrix(kind);
      set_idle_mode(mode);
      repeat (count) send_word(random_word());
      drain_pipeline();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_cases();
      test_random_phase(MATRIX_RANDOM,   IDLE_NONE,     300);
      test_random_phase(MATRIX_RANDOM,   IDLE_SENDER,   250);
      test_random_phase(MATRIX_SPARSE,   IDLE_RECEIVER, 250);
      test_random_phase(MATRIX_RANDOM,   IDLE_BOTH,     250);
      test_random_phase(MATRIX_ONES,     IDLE_NONE,     150);
      test_random_phase(MATRIX_REPEATED, IDLE_BOTH,     250);
      test_random_phase(MATRIX_RANDOM,   IDLE_RECEIVER, 250);
      test_random_phase(MATRIX_SPARSE,   IDLE_SENDER,   200);
      test_random_phase(MATRIX_ZERO,     IDLE_BOTH,     100);

      if (mismatch_count == 0) begin
         $display("double_error_syndrome_corrector regression: pass");
      end else begin
         $display("double_error_syndrome_corrector regression: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/desc_pkg.sv
hdl/desc_syndrome.sv
hdl/desc_match.sv
hdl/desc_locate.sv
hdl/desc_correct.sv
hdl/double_error_syndrome_corrector.sv
hdl/desc_checker.sv
verif/double_error_syndrome_corrector_tb.sv
